FILE: rtl/sci_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the segment/circle intersection block.
// No dependencies.
package sci_pkg;

  localparam int unsigned Lanes   = 4;
  localparam int unsigned LaneP0X = 0;
  localparam int unsigned LaneP0Y = 1;
  localparam int unsigned LaneP1X = 2;
  localparam int unsigned LaneP1Y = 3;

  typedef struct packed {
    logic zero_len;
    logic on_circ;
    logic disc_ge;
    logic disc_zero;
  } sci_flags_t;

endpackage

FILE: rtl/sci_sqrt_cell.sv
`timescale 1ns / 1ps
// One cell of the floored square root chain: settles one root bit per item.
// No dependencies.
module sci_sqrt_cell #(
  parameter int unsigned SW = 34,
  parameter int unsigned TW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*SW-1:0] rad_i,
  input  logic [SW+1:0]   rem_i,
  input  logic [SW-1:0]   root_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [2*SW-1:0] rad_o,
  output logic [SW+1:0]   rem_o,
  output logic [SW-1:0]   root_o,
  output logic [TW-1:0]   tag_o
);

  logic [SW+3:0] remw;
  logic [SW+3:0] trial;
  logic [SW+3:0] diff;
  logic          fits;
  logic [SW+1:0] rem_d;
  logic [SW-1:0] root_d;
  logic          valid_q;

  always_comb begin
    remw   = {rem_i, rad_i[2*SW-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    diff   = remw - trial;
    fits   = (remw >= trial);
    rem_d  = fits ? diff[SW+1:0] : remw[SW+1:0];
    root_d = {root_i[SW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*SW-3:0], 2'b00};
      rem_o  <= rem_d;
      root_o <= root_d;
      tag_o  <= tag_i;
    end
  end

  assign valid_o = valid_q;

endmodule

FILE: rtl/sci_div_cell.sv
`timescale 1ns / 1ps
// One cell of the divider chain: one quotient bit for each of four lanes.
// Depends on sci_pkg.
module sci_div_cell import sci_pkg::*; #(
  parameter int unsigned AW = 34,
  parameter int unsigned QW = 17,
  parameter int unsigned TW = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [AW-1:0]              den_i,
  input  logic [Lanes-1:0][AW-1:0]   rem_i,
  input  logic [Lanes-1:0][QW-1:0]   lo_i,
  input  logic [Lanes-1:0][QW-1:0]   quo_i,
  input  logic [TW-1:0]              tag_i,
  output logic                       valid_o,
  output logic [AW-1:0]              den_o,
  output logic [Lanes-1:0][AW-1:0]   rem_o,
  output logic [Lanes-1:0][QW-1:0]   lo_o,
  output logic [Lanes-1:0][QW-1:0]   quo_o,
  output logic [TW-1:0]              tag_o
);

  logic [Lanes-1:0][AW:0]   remw;
  logic [Lanes-1:0][AW:0]   diff;
  logic [Lanes-1:0]         fits;
  logic [Lanes-1:0][AW-1:0] rem_d;
  logic [Lanes-1:0][QW-1:0] lo_d;
  logic [Lanes-1:0][QW-1:0] quo_d;
  logic                     valid_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      remw[l]  = {rem_i[l], lo_i[l][QW-1]};
      diff[l]  = remw[l] - {1'b0, den_i};
      fits[l]  = (remw[l] >= {1'b0, den_i});
      rem_d[l] = fits[l] ? diff[l][AW-1:0] : remw[l][AW-1:0];
      lo_d[l]  = {lo_i[l][QW-2:0], 1'b0};
      quo_d[l] = {quo_i[l][QW-2:0], fits[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      rem_o <= rem_d;
      lo_o  <= lo_d;
      quo_o <= quo_d;
      tag_o <= tag_i;
    end
  end

  assign valid_o = valid_q;

endmodule

FILE: rtl/segment_circle_intersection.sv
`timescale 1ns / 1ps
// Segment / circle intersection: up to two points where a circle meets a segment.
// Depends on sci_pkg, sci_sqrt_cell, sci_div_cell.
//
// Usage: the input channel (valid_i / stall_o) carries one item per segment:
// its endpoints, the circle center and the radius, all on the same fixed-point
// scale. The output channel (valid_o / stall_i) returns one item per input
// item, in order: the hit count and up to two points, unused points zero.
// Throughput is one item per cycle while stall_o is low. Pipeline: six
// arithmetic stages, a square root chain of 2*COORD_BITS+2 cells (one root
// bit each), a divider chain of COORD_BITS+1 cells (one quotient bit each,
// four lanes) and the output register.
// Behind the output register sits one skid register; the pipeline stops
// and stall_o rises only once the skid register is full, so a stalled
// receiver costs no throughput until a second item backs up.
// Reset clears every valid flag; no item is in flight afterward.
module segment_circle_intersection import sci_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic        [COORD_BITS-1:0] radius_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic        [1:0]            hit_count_o,
  output logic signed [COORD_BITS-1:0] first_x_o,
  output logic signed [COORD_BITS-1:0] first_y_o,
  output logic signed [COORD_BITS-1:0] second_x_o,
  output logic signed [COORD_BITS-1:0] second_y_o
);

  localparam int unsigned N    = COORD_BITS;
  localparam int unsigned DW   = N + 1;
  localparam int unsigned AW   = 2 * N + 2;
  localparam int unsigned RW   = 2 * N;
  localparam int unsigned HW   = 2 * N + 3;
  localparam int unsigned PW   = 4 * N + 4;
  localparam int unsigned SW   = 2 * N + 2;
  localparam int unsigned NW   = 2 * N + 4;
  localparam int unsigned QW   = N + 1;
  localparam int unsigned NUMW = 3 * N + 3;
  localparam int unsigned TW1  = NW + AW + 2 * N + 2 * DW + $bits(sci_flags_t);
  localparam int unsigned TW2  = 2 * N + 6;
  localparam int unsigned RESW = 2 + 4 * N;

  logic en;
  logic out_v_q;
  logic skid_v_q;
  logic take;
  logic arrive;

  assign en      = !skid_v_q;
  assign stall_o = skid_v_q;

  // stage 1: differences
  logic signed [DW-1:0] sx_w, sy_w, ex_w, ey_w, cx_w, cy_w;
  logic                 v1_q;
  logic signed [N-1:0]  sx1_q, sy1_q;
  logic signed [DW-1:0] dx1_q, dy1_q, fx1_q, fy1_q;
  logic [N-1:0]         r1_q;

  assign sx_w = {start_x_i[N-1], start_x_i};
  assign sy_w = {start_y_i[N-1], start_y_i};
  assign ex_w = {end_x_i[N-1], end_x_i};
  assign ey_w = {end_y_i[N-1], end_y_i};
  assign cx_w = {center_x_i[N-1], center_x_i};
  assign cy_w = {center_y_i[N-1], center_y_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx1_q <= start_x_i;
      sy1_q <= start_y_i;
      dx1_q <= ex_w - sx_w;
      dy1_q <= ey_w - sy_w;
      fx1_q <= sx_w - cx_w;
      fy1_q <= sy_w - cy_w;
      r1_q  <= radius_i;
    end
  end

  // stage 2: dot, cross and squared lengths
  logic signed [2*DW-1:0] m_dxdx, m_dydy, m_fxfx, m_fyfy, m_fxdx, m_fydy, m_fxdy, m_fydx;
  logic                   v2_q;
  logic [AW-1:0]          a2_q, f2_q;
  logic [RW-1:0]          r2_q;
  logic signed [HW-1:0]   h2_q, k2_q;
  logic signed [N-1:0]    sx2_q, sy2_q;
  logic signed [DW-1:0]   dx2_q, dy2_q;

  assign m_dxdx = dx1_q * dx1_q;
  assign m_dydy = dy1_q * dy1_q;
  assign m_fxfx = fx1_q * fx1_q;
  assign m_fyfy = fy1_q * fy1_q;
  assign m_fxdx = fx1_q * dx1_q;
  assign m_fydy = fy1_q * dy1_q;
  assign m_fxdy = fx1_q * dy1_q;
  assign m_fydx = fy1_q * dx1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q  <= AW'($unsigned(m_dxdx)) + AW'($unsigned(m_dydy));
      f2_q  <= AW'($unsigned(m_fxfx)) + AW'($unsigned(m_fyfy));
      r2_q  <= r1_q * r1_q;
      h2_q  <= HW'(m_fxdx) + HW'(m_fydy);
      k2_q  <= HW'(m_fxdy) - HW'(m_fydx);
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
    end
  end

  // stage 3: a*r^2 and k^2
  logic signed [HW-1:0] kneg;
  logic [AW-1:0]        kabs;
  logic                 v3_q;
  logic [PW-1:0]        ar2_q, ksq_q;
  logic                 zl3_q, oc3_q;
  logic signed [HW-1:0] h3_q;
  logic [AW-1:0]        a3_q;
  logic signed [N-1:0]  sx3_q, sy3_q;
  logic signed [DW-1:0] dx3_q, dy3_q;

  assign kneg = -k2_q;
  assign kabs = k2_q[HW-1] ? kneg[AW-1:0] : k2_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ar2_q <= a2_q * r2_q;
      ksq_q <= kabs * kabs;
      zl3_q <= (a2_q == '0);
      oc3_q <= (f2_q == AW'(r2_q));
      h3_q  <= h2_q;
      a3_q  <= a2_q;
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
      dx3_q <= dx2_q;
      dy3_q <= dy2_q;
    end
  end

  // stage 4: discriminant
  logic signed [NW-1:0] hx;
  logic                 v4_q;
  logic [PW-1:0]        disc4_q;
  logic signed [NW-1:0] hneg4_q;
  sci_flags_t           fl4_q;
  logic [AW-1:0]        a4_q;
  logic signed [N-1:0]  sx4_q, sy4_q;
  logic signed [DW-1:0] dx4_q, dy4_q;

  assign hx = NW'(h3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc4_q         <= ar2_q - ksq_q;
      hneg4_q         <= -hx;
      fl4_q.zero_len  <= zl3_q;
      fl4_q.on_circ   <= oc3_q;
      fl4_q.disc_ge   <= (ar2_q >= ksq_q);
      fl4_q.disc_zero <= (ar2_q == ksq_q);
      a4_q            <= a3_q;
      sx4_q           <= sx3_q;
      sy4_q           <= sy3_q;
      dx4_q           <= dx3_q;
      dy4_q           <= dy3_q;
    end
  end

  // square root chain
  logic            sq_v    [SW+1];
  logic [2*SW-1:0] sq_rad  [SW+1];
  logic [SW+1:0]   sq_rem  [SW+1];
  logic [SW-1:0]   sq_root [SW+1];
  logic [TW1-1:0]  sq_tag  [SW+1];

  assign sq_v[0]    = v4_q;
  assign sq_rad[0]  = disc4_q[2*SW-1:0];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_tag[0]  = {hneg4_q, a4_q, sx4_q, sy4_q, dx4_q, dy4_q, fl4_q};

  for (genvar g = 0; g < SW; g++) begin : g_sqrt
    sci_sqrt_cell #(
      .SW(SW),
      .TW(TW1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[g]),
      .rad_i   (sq_rad[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .tag_i   (sq_tag[g]),
      .valid_o (sq_v[g+1]),
      .rad_o   (sq_rad[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1]),
      .tag_o   (sq_tag[g+1])
    );
  end

  logic signed [NW-1:0] hneg_e;
  logic [AW-1:0]        a_e;
  logic signed [N-1:0]  sx_e, sy_e;
  logic signed [DW-1:0] dx_e, dy_e;
  sci_flags_t           fl_e;

  assign {hneg_e, a_e, sx_e, sy_e, dx_e, dy_e, fl_e} = sq_tag[SW];

  // stage 5: roots, range checks, magnitudes
  logic signed [NW-1:0] s_ext, n0_d, n1_d;
  logic signed [DW-1:0] dxn, dyn;
  logic                 v5_q;
  logic signed [NW-1:0] n0_5_q, n1_5_q;
  logic                 r0ok5_q, r1ok5_q, zl5_q, oc5_q, sgx5_q, sgy5_q;
  logic [AW-1:0]        a5_q;
  logic [QW-1:0]        adx5_q, ady5_q;
  logic signed [N-1:0]  sx5_q, sy5_q;

  assign s_ext = {2'b00, sq_root[SW]};
  assign n0_d  = hneg_e + s_ext;
  assign n1_d  = hneg_e - s_ext;
  assign dxn   = -dx_e;
  assign dyn   = -dy_e;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n0_5_q  <= n0_d;
      n1_5_q  <= n1_d;
      r0ok5_q <= fl_e.disc_ge && !fl_e.zero_len && !n0_d[NW-1] &&
                 ($unsigned(n0_d) <= {2'b00, a_e});
      r1ok5_q <= fl_e.disc_ge && !fl_e.zero_len && !fl_e.disc_zero && !n1_d[NW-1] &&
                 ($unsigned(n1_d) <= {2'b00, a_e});
      zl5_q   <= fl_e.zero_len;
      oc5_q   <= fl_e.on_circ;
      a5_q    <= a_e;
      adx5_q  <= dx_e[DW-1] ? dxn : dx_e;
      ady5_q  <= dy_e[DW-1] ? dyn : dy_e;
      sgx5_q  <= dx_e[DW-1];
      sgy5_q  <= dy_e[DW-1];
      sx5_q   <= sx_e;
      sy5_q   <= sy_e;
    end
  end

  // stage 6: numerators
  logic                        v6_q;
  logic [Lanes-1:0][NUMW-1:0]  num6_q;
  logic [AW-1:0]               a6_q;
  logic signed [N-1:0]         sx6_q, sy6_q;
  logic                        sgx6_q, sgy6_q, zl6_q, oc6_q, r0ok6_q, r1ok6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num6_q[LaneP0X] <= adx5_q * n0_5_q[AW-1:0];
      num6_q[LaneP0Y] <= ady5_q * n0_5_q[AW-1:0];
      num6_q[LaneP1X] <= adx5_q * n1_5_q[AW-1:0];
      num6_q[LaneP1Y] <= ady5_q * n1_5_q[AW-1:0];
      a6_q            <= a5_q;
      sx6_q           <= sx5_q;
      sy6_q           <= sy5_q;
      sgx6_q          <= sgx5_q;
      sgy6_q          <= sgy5_q;
      zl6_q           <= zl5_q;
      oc6_q           <= oc5_q;
      r0ok6_q         <= r0ok5_q;
      r1ok6_q         <= r1ok5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= sq_v[SW];
      v6_q <= v5_q;
    end
  end

  // divider chain
  logic                      dv_v   [QW+1];
  logic [AW-1:0]             dv_den [QW+1];
  logic [Lanes-1:0][AW-1:0]  dv_rem [QW+1];
  logic [Lanes-1:0][QW-1:0]  dv_lo  [QW+1];
  logic [Lanes-1:0][QW-1:0]  dv_quo [QW+1];
  logic [TW2-1:0]            dv_tag [QW+1];

  assign dv_v[0]   = v6_q;
  assign dv_den[0] = a6_q;
  assign dv_quo[0] = '0;
  assign dv_tag[0] = {sx6_q, sy6_q, sgx6_q, sgy6_q, zl6_q, oc6_q, r0ok6_q, r1ok6_q};

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      dv_rem[0][l] = num6_q[l][NUMW-1:QW];
      dv_lo[0][l]  = num6_q[l][QW-1:0];
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    sci_div_cell #(
      .AW(AW),
      .QW(QW),
      .TW(TW2)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[g]),
      .den_i   (dv_den[g]),
      .rem_i   (dv_rem[g]),
      .lo_i    (dv_lo[g]),
      .quo_i   (dv_quo[g]),
      .tag_i   (dv_tag[g]),
      .valid_o (dv_v[g+1]),
      .den_o   (dv_den[g+1]),
      .rem_o   (dv_rem[g+1]),
      .lo_o    (dv_lo[g+1]),
      .quo_o   (dv_quo[g+1]),
      .tag_o   (dv_tag[g+1])
    );
  end

  // rounding, point assembly
  logic signed [N-1:0]       sx_f, sy_f;
  logic                      sgx_f, sgy_f, zl_f, oc_f, r0ok_f, r1ok_f;
  logic [Lanes-1:0][N-1:0]   base;
  logic [Lanes-1:0]          sgn;
  logic [Lanes-1:0]          rnd;
  logic [Lanes-1:0][QW:0]    qr;
  logic [Lanes-1:0][N+1:0]   ext;
  logic [Lanes-1:0][N+1:0]   crd;
  logic [Lanes-1:0][N-1:0]   pt;
  logic [1:0]                hits;
  logic [N-1:0]              p1x, p1y, p2x, p2y;
  logic [RESW-1:0]           res;

  assign {sx_f, sy_f, sgx_f, sgy_f, zl_f, oc_f, r0ok_f, r1ok_f} = dv_tag[QW];

  assign base[LaneP0X] = sx_f;
  assign base[LaneP0Y] = sy_f;
  assign base[LaneP1X] = sx_f;
  assign base[LaneP1Y] = sy_f;
  assign sgn[LaneP0X]  = sgx_f;
  assign sgn[LaneP0Y]  = sgy_f;
  assign sgn[LaneP1X]  = sgx_f;
  assign sgn[LaneP1Y]  = sgy_f;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      rnd[l] = ({dv_rem[QW][l], 1'b0} >= {1'b0, dv_den[QW]});
      qr[l]  = {1'b0, dv_quo[QW][l]} + (QW+1)'(rnd[l]);
      ext[l] = {{2{base[l][N-1]}}, base[l]};
      crd[l] = sgn[l] ? (ext[l] - qr[l]) : (ext[l] + qr[l]);
      pt[l]  = crd[l][N-1:0];
    end
  end

  always_comb begin
    hits = 2'd0;
    p1x  = '0;
    p1y  = '0;
    p2x  = '0;
    p2y  = '0;
    if (zl_f) begin
      if (oc_f) begin
        hits = 2'd1;
        p1x  = sx_f;
        p1y  = sy_f;
      end
    end else begin
      case ({r0ok_f, r1ok_f})
        2'b11: begin
          hits = 2'd2;
          p1x  = pt[LaneP0X];
          p1y  = pt[LaneP0Y];
          p2x  = pt[LaneP1X];
          p2y  = pt[LaneP1Y];
        end
        2'b10: begin
          hits = 2'd1;
          p1x  = pt[LaneP0X];
          p1y  = pt[LaneP0Y];
        end
        2'b01: begin
          hits = 2'd1;
          p1x  = pt[LaneP1X];
          p1y  = pt[LaneP1Y];
        end
        default: begin
          hits = 2'd0;
        end
      endcase
    end
    res = {hits, p1x, p1y, p2x, p2y};
  end

  // output register and skid register
  logic [RESW-1:0] out_q;
  logic [RESW-1:0] skid_q;

  assign take   = out_v_q && !stall_i;
  assign arrive = en && dv_v[QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (arrive && out_v_q && !take) begin
      skid_v_q <= 1'b1;
    end else if (!out_v_q || take) begin
      out_v_q <= arrive;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (arrive && out_v_q && !take) begin
      skid_q <= res;
    end else if (!out_v_q || take) begin
      out_q <= res;
    end
  end

  assign valid_o     = out_v_q;
  assign hit_count_o = out_q[RESW-1 -: 2];
  assign first_x_o   = out_q[4*N-1 -: N];
  assign first_y_o   = out_q[3*N-1 -: N];
  assign second_x_o  = out_q[2*N-1 -: N];
  assign second_y_o  = out_q[N-1:0];

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hit_count_o != 2'd3))
    else $error("hit count out of range");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_count_o == 2'd0) |-> (first_x_o == '0 && first_y_o == '0))
    else $error("first point set without a hit");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_count_o != 2'd2) |-> (second_x_o == '0 && second_y_o == '0))
    else $error("second point set without two hits");

  a_skid_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && take) |=> (!skid_v_q && out_v_q))
    else $error("skid item not moved to output");

endmodule

FILE: sim/sci_checker.sv
`timescale 1ns / 1ps
// Checker for segment_circle_intersection: watches both channels, predicts
// each result from the accepted segment and circle, and compares in order.
// No dependencies.
module sci_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               stall_o,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] end_x_i,
  input  logic signed [15:0] end_y_i,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic        [15:0] radius_i,
  input  logic               valid_o,
  input  logic               stall_i,
  input  logic        [1:0]  hit_count_o,
  input  logic signed [15:0] first_x_o,
  input  logic signed [15:0] first_y_o,
  input  logic signed [15:0] second_x_o,
  input  logic signed [15:0] second_y_o,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 hit_seen_o [3]
);

  typedef struct packed {
    logic        [1:0]  cnt;
    logic signed [15:0] p0x;
    logic signed [15:0] p0y;
    logic signed [15:0] p1x;
    logic signed [15:0] p1y;
  } hits_t;

  hits_t expected_hits[$];

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint floor_sqrt(logic [127:0] v);
    logic [127:0] res;
    logic [127:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (128'(1) << b);
      if (cand * cand <= v) res = cand;
    end
    return longint'(res);
  endfunction

  // round d*n/a to nearest, halves away from the start point
  function automatic longint point_along(longint s, longint d, longint n, longint a);
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] rem;
    num = 128'(magnitude(d)) * 128'(n);
    q   = num / 128'(a);
    rem = num % 128'(a);
    if (rem >= 128'(a) - rem) q = q + 1;
    return d < 0 ? s - longint'(q) : s + longint'(q);
  endfunction

  function automatic hits_t predict_hits(logic signed [15:0] sx_c, logic signed [15:0] sy_c,
                                         logic signed [15:0] ex_c, logic signed [15:0] ey_c,
                                         logic signed [15:0] cx_c, logic signed [15:0] cy_c,
                                         logic [15:0] r_c);
    longint       dx, dy, fx, fy, a, r2, h, k, s, n;
    logic [127:0] ar2, k2, disc;
    longint       px[2];
    longint       py[2];
    int           hits, nroots;
    hits_t        res;
    dx = longint'(ex_c) - longint'(sx_c);
    dy = longint'(ey_c) - longint'(sy_c);
    fx = longint'(sx_c) - longint'(cx_c);
    fy = longint'(sy_c) - longint'(cy_c);
    a  = dx * dx + dy * dy;
    r2 = longint'({48'd0, r_c}) * longint'({48'd0, r_c});
    px = '{0, 0};
    py = '{0, 0};
    hits = 0;
    if (a == 0) begin
      if (fx * fx + fy * fy == r2) begin
        px[0] = sx_c;
        py[0] = sy_c;
        hits = 1;
      end
    end else begin
      h   = fx * dx + fy * dy;
      k   = fx * dy - fy * dx;
      ar2 = 128'(a) * 128'(r2);
      k2  = 128'(magnitude(k)) * 128'(magnitude(k));
      if (ar2 >= k2) begin
        disc   = ar2 - k2;
        s      = floor_sqrt(disc);
        nroots = (disc == 0) ? 1 : 2;
        for (int j = 0; j < nroots; j++) begin
          n = (j == 0) ? -h + s : -h - s;
          if (n >= 0 && n <= a) begin
            px[hits] = point_along(sx_c, dx, n, a);
            py[hits] = point_along(sy_c, dy, n, a);
            hits++;
          end
        end
      end
    end
    res.cnt = 2'(hits);
    res.p0x = px[0][15:0];
    res.p0y = py[0][15:0];
    res.p1x = px[1][15:0];
    res.p1y = py[1][15:0];
    return res;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    hit_seen_o   = '{0, 0, 0};
  end

  always @(posedge clk_i) begin
    hits_t want;
    if (rst_ni) begin
      if (valid_i && !stall_o)
        expected_hits.insert(expected_hits.size(),
                             predict_hits(start_x_i, start_y_i, end_x_i, end_y_i,
                                          center_x_i, center_y_i, radius_i));
      if (valid_o && !stall_i) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result, hit_count %0d", $time, hit_count_o);
          fail_count_o++;
        end else begin
          want = expected_hits.pop_front();
          compare_field("hit_count", want.cnt, hit_count_o);
          compare_field("first_x", want.p0x, first_x_o);
          compare_field("first_y", want.p0y, first_y_o);
          compare_field("second_x", want.p1x, second_x_o);
          compare_field("second_y", want.p1y, second_y_o);
          if (want.cnt < 3) hit_seen_o[want.cnt]++;
        end
      end
    end
    pending_o <= expected_hits.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for segment_circle_intersection: clock, reset, segment stimulus
// with random idling, watchdog and verdict. Depends on sci_checker and the DUT.
module tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic signed [15:0] start_x_i = '0;
  logic signed [15:0] start_y_i = '0;
  logic signed [15:0] end_x_i = '0;
  logic signed [15:0] end_y_i = '0;
  logic signed [15:0] center_x_i = '0;
  logic signed [15:0] center_y_i = '0;
  logic        [15:0] radius_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic        [1:0]  hit_count_o;
  logic signed [15:0] first_x_o, first_y_o, second_x_o, second_y_o;
  int                 fail_count, pending;
  int                 hit_seen [3];
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 quiet_cycles = 0;

  localparam int WatchdogLimit = 20000;

  always #10 clk_i = ~clk_i;

  segment_circle_intersection #(.COORD_BITS(16)) u_dut (.*);

  sci_checker u_chk (
    .fail_count_o(fail_count), .pending_o(pending), .hit_seen_o(hit_seen), .*
  );

  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_segment(int sx, int sy, int ex, int ey, int cx, int cy, int r);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i    <= 1'b1;
    start_x_i  <= 16'(sx);
    start_y_i  <= 16'(sy);
    end_x_i    <= 16'(ex);
    end_y_i    <= 16'(ey);
    center_x_i <= 16'(cx);
    center_y_i <= 16'(cy);
    radius_i   <= 16'(r);
    do @(posedge clk_i); while (stall_o);
  endtask

  task automatic drain_results();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // mostly segments near a circle, so roots land on and off the segment
  task automatic send_random();
    int cx, cy, r, span;
    if ($urandom_range(99) < 20) begin
      send_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      cx   = $urandom_range(16000) - 8000;
      cy   = $urandom_range(16000) - 8000;
      r    = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(3000);
      span = 2 * r + 16;
      send_segment(cx + $urandom_range(2 * span) - span, cy + $urandom_range(2 * span) - span,
                   cx + $urandom_range(2 * span) - span, cy + $urandom_range(2 * span) - span,
                   cx, cy, r);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_segment(0, 0, 0, 0, 0, 0, 0);
    send_segment(256, 0, 256, 0, 0, 0, 256);
    send_segment(300, 0, 300, 0, 0, 0, 256);
    send_segment(-512, 256, 512, 256, 0, 0, 256);
    send_segment(-1024, 0, 1024, 0, 0, 0, 256);
    send_segment(0, 0, 1024, 0, 0, 0, 256);
    send_segment(1024, 0, 0, 0, 0, 0, 256);
    send_segment(-1024, 100, -600, 100, 0, 0, 256);
    send_segment(-100, -100, 100, 100, 0, 0, 2000);
    send_segment(5, 7, 5, 7, 5, 7, 0);
    send_segment(-10, 0, 10, 0, 0, 0, 0);
    send_segment(-32768, -32768, 32767, 32767, 0, 0, 65535);
    send_segment(32767, -32768, -32768, 32767, -32768, 32767, 65535);
    send_segment(-32768, -32768, 32767, 32767, 32767, -32768, 0);
    send_segment(32767, 32767, 32767, 32767, -32768, -32768, 65535);
    send_segment(-32768, 0, 32767, 0, 0, 0, 32768);
    send_segment(0, -32768, 0, 32767, 0, 0, 65535);
    send_segment(0, 0, 3, 1, 1, 2, 1);
    drain_results();

    send_idle_pct = 20;
    recv_stall_pct = 81;
    repeat (150) send_random();
    drain_results();

    send_idle_pct = 81;
    recv_stall_pct = 20;
    repeat (150) send_random();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (150) send_random();
    drain_results();
    repeat (70) @(posedge clk_i);

    $display("Covered directed edge cases and random segments under mixed idling;");
    $display("results seen with 0/1/2 hits: %0d/%0d/%0d", hit_seen[0], hit_seen[1],
             hit_seen[2]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: segment_circle_intersection.f
rtl/sci_pkg.sv
rtl/sci_sqrt_cell.sv
rtl/sci_div_cell.sv
rtl/segment_circle_intersection.sv
sim/sci_checker.sv
sim/tb.sv
